### rtl/core/circle_overlap_separation_top_assert.svh
// Assertion macros used by the checker file cos_checker.sv.
`ifndef CIRCLE_OVERLAP_SEPARATION_TOP_ASSERT_SVH
`define CIRCLE_OVERLAP_SEPARATION_TOP_ASSERT_SVH
`define COS_ASSERT_IMP(lbl, clk, rst, a, b, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) else $error(msg);
`define COS_ASSERT_NXT(lbl, clk, rst, a, b, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) else $error(msg);
`define COS_ASSERT_RST(lbl, clk, a, b, msg) \
   lbl: assert property (@(posedge clk) (a) |=> (b)) else $error(msg);
`endif

### rtl/core/cos_pkg.sv
package cos_pkg;
   localparam int CoordW = 32;
   localparam int RadW = 31;
   localparam int SumW = 48;
   localparam int CntW = 9;
   localparam int HitW = 8;
   localparam int SelfIdxW = 8;
   localparam int CsrIdxW = 3;
   localparam int CsrDataW = 32;

   typedef enum logic [CsrIdxW-1:0] {
      CSR_SELF_X = 3'd0,
      CSR_SELF_Y = 3'd1,
      CSR_SELF_RADIUS = 3'd2,
      CSR_SELF_INDEX = 3'd3,
      CSR_COLLISION_ENABLE = 3'd4
   } csr_idx_type;

   typedef struct packed {
      logic signed [CoordW-1:0] self_x;
      logic signed [CoordW-1:0] self_y;
      logic [RadW-1:0] self_radius;
      logic [SelfIdxW-1:0] self_index;
      logic collision_enable;
   } cfg_type;

   typedef struct packed {
      logic cand;
      logic last;
      logic neg_x;
      logic neg_y;
      logic [31:0] adx;
      logic [31:0] ady;
      logic [31:0] rsum;
   } entry_type;

   typedef struct packed {
      logic start;
      logic [6:0] iters;
      logic [31:0] rem;
      logic [63:0] shift;
      logic [31:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic busy;
      logic done;
      logic [63:0] quo;
   } div_rsp_type;

   typedef enum logic [4:0] {
      ST_IDLE, ST_DISPATCH, ST_SQ_X, ST_SQ_Y, ST_SQ_R, ST_CHECK, ST_SQRT, ST_HIT,
      ST_MUL_X, ST_DIVX_GO, ST_DIVX_WAIT, ST_MUL_Y, ST_DIVY_GO, ST_DIVY_WAIT,
      ST_END_CHK, ST_MEANX_GO, ST_MEANX_WAIT, ST_MEANY_GO, ST_MEANY_WAIT, ST_OUT
   } back_state_type;
endpackage

### rtl/core/cos_if.sv
interface cos_req_if;
   import cos_pkg::*;
   logic valid;
   logic ready;
   logic signed [CoordW-1:0] other_x;
   logic signed [CoordW-1:0] other_y;
   logic [RadW-1:0] other_radius;
   logic last_circle;
   modport source (output valid, other_x, other_y, other_radius, last_circle, input ready);
   modport sink (input valid, other_x, other_y, other_radius, last_circle, output ready);
endinterface

interface cos_rsp_if;
   import cos_pkg::*;
   logic valid;
   logic ready;
   logic [CntW-1:0] collision_count;
   logic signed [CoordW-1:0] mean_sep_x;
   logic signed [CoordW-1:0] mean_sep_y;
   modport source (output valid, collision_count, mean_sep_x, mean_sep_y, input ready);
   modport sink (input valid, collision_count, mean_sep_x, mean_sep_y, output ready);
endinterface

### rtl/core/cos_front.sv
module cos_front import cos_pkg::*; #(
   parameter int MAX_CIRCLES = 256
) (
   input logic clock,
   input logic reset,
   input cfg_type cfg,
   cos_req_if.sink req_if,
   input logic fifo_full,
   output logic push,
   output entry_type push_entry
);
   localparam int IdxW = (MAX_CIRCLES > 2) ? $clog2(MAX_CIRCLES) : 1;
   localparam int CmpW = (IdxW > SelfIdxW) ? IdxW : SelfIdxW;

   logic [IdxW-1:0] idx_ff, idx_in;
   logic signed [32:0] dx, dy;
   logic [32:0] adx, ady;
   logic [31:0] rsum;
   logic accept;

   assign req_if.ready = !fifo_full;
   assign accept = req_if.valid && req_if.ready;
   assign push = accept;

   always_comb begin
      dx = 33'(cfg.self_x) - 33'(req_if.other_x);
      dy = 33'(cfg.self_y) - 33'(req_if.other_y);
      adx = dx[32] ? 33'(-dx) : 33'(dx);
      ady = dy[32] ? 33'(-dy) : 33'(dy);
      rsum = 32'(cfg.self_radius) + 32'(req_if.other_radius);
      push_entry.cand = cfg.collision_enable && (CmpW'(idx_ff) != CmpW'(cfg.self_index))
         && (adx < {1'b0, rsum}) && (ady < {1'b0, rsum});
      push_entry.last = req_if.last_circle;
      push_entry.neg_x = dx[32];
      push_entry.neg_y = dy[32];
      push_entry.adx = adx[31:0];
      push_entry.ady = ady[31:0];
      push_entry.rsum = rsum;
   end

   always_comb begin
      idx_in = idx_ff;
      if (accept) begin
         if (req_if.last_circle || idx_ff == IdxW'(MAX_CIRCLES - 1)) begin
            idx_in = '0;
         end else begin
            idx_in = idx_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
      end else begin
         idx_ff <= idx_in;
      end
   end
endmodule

### rtl/core/cos_fifo.sv
module cos_fifo import cos_pkg::*; (
   input logic clock,
   input logic reset,
   input logic push,
   input entry_type push_entry,
   input logic pop,
   output logic full,
   output logic not_empty,
   output entry_type head
);
   localparam int Depth = 4;
   localparam int PtrW = 2;

   entry_type mem_ff [Depth];
   logic [PtrW-1:0] wr_ff, rd_ff;
   logic [PtrW:0] cnt_ff;

   assign full = (cnt_ff == (PtrW+1)'(Depth));
   assign not_empty = (cnt_ff != '0);
   assign head = mem_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) begin
            wr_ff <= wr_ff + 1'b1;
         end
         if (pop) begin
            rd_ff <= rd_ff + 1'b1;
         end
         cnt_ff <= cnt_ff + (PtrW+1)'(push) - (PtrW+1)'(pop);
      end
   end
endmodule

### rtl/core/cos_div.sv
module cos_div import cos_pkg::*; (
   input logic clock,
   input logic reset,
   input div_req_type dreq,
   output div_rsp_type drsp
);
   logic busy_ff, done_ff;
   logic [6:0] cnt_ff;
   logic [31:0] rem_ff, rem_in, div_ff;
   logic [63:0] sh_ff, sh_in;
   logic [32:0] r33;
   logic ge;

   always_comb begin
      r33 = {rem_ff, sh_ff[63]};
      ge = (r33 >= {1'b0, div_ff});
      rem_in = ge ? 32'(r33 - {1'b0, div_ff}) : r33[31:0];
      sh_in = {sh_ff[62:0], ge};
   end

   assign drsp.busy = busy_ff;
   assign drsp.done = done_ff;
   assign drsp.quo = sh_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (dreq.start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && cnt_ff == 7'd1) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (dreq.start) begin
         cnt_ff <= dreq.iters;
         rem_ff <= dreq.rem;
         sh_ff <= dreq.shift;
         div_ff <= dreq.divisor;
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff - 1'b1;
         rem_ff <= rem_in;
         sh_ff <= sh_in;
      end
   end
endmodule

### rtl/core/cos_back.sv
module cos_back import cos_pkg::*; (
   input logic clock,
   input logic reset,
   input logic collision_enable,
   input logic fifo_not_empty,
   input entry_type head,
   output logic pop,
   cos_rsp_if.source rsp_if
);
   back_state_type state_ff, state_in;
   entry_type ent_ff;
   logic [63:0] dx2_ff, dy2_ff, r2_ff, prod_ff, product;
   logic [63:0] v_ff, res_ff, bit_ff, rb;
   logic [5:0] scnt_ff;
   logic [31:0] len_ff, mag_ff, mul_a, mul_b;
   logic signed [SumW-1:0] sum_x_ff, sum_y_ff;
   logic [HitW-1:0] hit_ff;
   logic [31:0] mean_x_ff, mean_y_ff;
   logic rsp_valid_ff;
   logic [CntW-1:0] cnt_out_ff;
   logic [31:0] mx_out_ff, my_out_ff;
   logic out_free, in_circle, sq_ge;
   logic [47:0] q48;
   logic signed [SumW-1:0] qs;
   div_req_type dreq;
   div_rsp_type drsp;

   function automatic logic [31:0] sat_mean(input logic neg, input logic [47:0] q);
      logic [31:0] r;
      if (!neg) begin
         r = (q > 48'h0000_7FFF_FFFF) ? 32'h7FFF_FFFF : q[31:0];
      end else begin
         r = (q > 48'h0000_8000_0000) ? 32'h8000_0000 : 32'(-q[31:0]);
      end
      return r;
   endfunction

   cos_div u_div (.clock(clock), .reset(reset), .dreq(dreq), .drsp(drsp));

   assign out_free = !rsp_valid_ff || rsp_if.ready;
   assign rsp_if.valid = rsp_valid_ff;
   assign rsp_if.collision_count = cnt_out_ff;
   assign rsp_if.mean_sep_x = mx_out_ff;
   assign rsp_if.mean_sep_y = my_out_ff;
   assign in_circle = (dy2_ff < r2_ff) && (dx2_ff < r2_ff - dy2_ff);
   assign rb = res_ff + bit_ff;
   assign sq_ge = (v_ff >= rb);
   assign product = 64'(mul_a) * 64'(mul_b);
   assign q48 = drsp.quo[47:0];
   assign qs = SumW'(drsp.quo[31:0]);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (fifo_not_empty) state_in = ST_DISPATCH;
         ST_DISPATCH: state_in = (ent_ff.cand && hit_ff != 8'hFF) ? ST_SQ_X : ST_END_CHK;
         ST_SQ_X: state_in = ST_SQ_Y;
         ST_SQ_Y: state_in = ST_SQ_R;
         ST_SQ_R: state_in = ST_CHECK;
         ST_CHECK: state_in = in_circle ? ST_SQRT : ST_END_CHK;
         ST_SQRT: if (scnt_ff == 6'd1) state_in = ST_HIT;
         ST_HIT: state_in = (res_ff[31:0] == '0) ? ST_END_CHK : ST_MUL_X;
         ST_MUL_X: state_in = ST_DIVX_GO;
         ST_DIVX_GO: state_in = ST_DIVX_WAIT;
         ST_DIVX_WAIT: if (drsp.done) state_in = ST_MUL_Y;
         ST_MUL_Y: state_in = ST_DIVY_GO;
         ST_DIVY_GO: state_in = ST_DIVY_WAIT;
         ST_DIVY_WAIT: if (drsp.done) state_in = ST_END_CHK;
         ST_END_CHK: begin
            if (!ent_ff.last) begin
               state_in = ST_IDLE;
            end else if (collision_enable && hit_ff != '0) begin
               state_in = ST_MEANX_GO;
            end else begin
               state_in = ST_OUT;
            end
         end
         ST_MEANX_GO: state_in = ST_MEANX_WAIT;
         ST_MEANX_WAIT: if (drsp.done) state_in = ST_MEANY_GO;
         ST_MEANY_GO: state_in = ST_MEANY_WAIT;
         ST_MEANY_WAIT: if (drsp.done) state_in = ST_OUT;
         ST_OUT: if (out_free) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      pop = 1'b0;
      mul_a = ent_ff.adx;
      mul_b = ent_ff.adx;
      dreq = '0;
      case (state_ff)
         ST_IDLE: pop = fifo_not_empty;
         ST_SQ_Y: begin
            mul_a = ent_ff.ady;
            mul_b = ent_ff.ady;
         end
         ST_SQ_R: begin
            mul_a = ent_ff.rsum;
            mul_b = ent_ff.rsum;
         end
         ST_MUL_X: mul_b = mag_ff;
         ST_MUL_Y: begin
            mul_a = ent_ff.ady;
            mul_b = mag_ff;
         end
         ST_DIVX_GO, ST_DIVY_GO: begin
            dreq.start = 1'b1;
            dreq.iters = 7'd32;
            dreq.rem = prod_ff[63:32];
            dreq.shift = {prod_ff[31:0], 32'd0};
            dreq.divisor = len_ff;
         end
         ST_MEANX_GO, ST_MEANY_GO: begin
            dreq.start = 1'b1;
            dreq.iters = 7'd48;
            dreq.divisor = 32'(hit_ff);
            if (state_ff == ST_MEANX_GO) begin
               dreq.shift = {48'(sum_x_ff[SumW-1] ? -sum_x_ff : sum_x_ff), 16'd0};
            end else begin
               dreq.shift = {48'(sum_y_ff[SumW-1] ? -sum_y_ff : sum_y_ff), 16'd0};
            end
         end
         default: pop = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         sum_x_ff <= '0;
         sum_y_ff <= '0;
         hit_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_OUT && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_if.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_HIT: hit_ff <= hit_ff + 1'b1;
            ST_DIVX_WAIT: if (drsp.done) sum_x_ff <= ent_ff.neg_x ? sum_x_ff - qs : sum_x_ff + qs;
            ST_DIVY_WAIT: if (drsp.done) sum_y_ff <= ent_ff.neg_y ? sum_y_ff - qs : sum_y_ff + qs;
            ST_OUT: begin
               if (out_free) begin
                  sum_x_ff <= '0;
                  sum_y_ff <= '0;
                  hit_ff <= '0;
               end
            end
            default: hit_ff <= hit_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: ent_ff <= head;
         ST_SQ_X: dx2_ff <= product;
         ST_SQ_Y: dy2_ff <= product;
         ST_SQ_R: r2_ff <= product;
         ST_CHECK: begin
            v_ff <= dx2_ff + dy2_ff;
            res_ff <= '0;
            bit_ff <= 64'h4000_0000_0000_0000;
            scnt_ff <= 6'd32;
         end
         ST_SQRT: begin
            v_ff <= sq_ge ? v_ff - rb : v_ff;
            res_ff <= sq_ge ? (res_ff >> 1) + bit_ff : res_ff >> 1;
            bit_ff <= bit_ff >> 2;
            scnt_ff <= scnt_ff - 1'b1;
         end
         ST_HIT: begin
            len_ff <= res_ff[31:0];
            mag_ff <= ent_ff.rsum - res_ff[31:0];
         end
         ST_MUL_X, ST_MUL_Y: prod_ff <= product;
         ST_MEANX_WAIT: if (drsp.done) mean_x_ff <= sat_mean(sum_x_ff[SumW-1], q48);
         ST_MEANY_WAIT: if (drsp.done) mean_y_ff <= sat_mean(sum_y_ff[SumW-1], q48);
         ST_OUT: begin
            if (out_free) begin
               if (collision_enable && hit_ff != '0) begin
                  cnt_out_ff <= CntW'(hit_ff) + 1'b1;
                  mx_out_ff <= mean_x_ff;
                  my_out_ff <= mean_y_ff;
               end else begin
                  cnt_out_ff <= '0;
                  mx_out_ff <= '0;
                  my_out_ff <= '0;
               end
            end
         end
         default: len_ff <= len_ff;
      endcase
   end
endmodule

### rtl/core/circle_overlap_separation_top.sv
// Circle overlap separation.
// Requests on req_if carry one other circle each (centre, radius, last flag);
// the query circle is written beforehand through csr_write_en/csr_index/csr_wdata.
// One response leaves on rsp_if for each request marked last_circle: the
// overlap count plus one (0 when nothing overlapped or detection is off) and
// the mean separation vector, saturated to 32 bits.
// A front stage classifies each request in the cycle it is taken and places it
// in a four-entry queue, so up to four requests are taken at one per cycle.
// The back sequencer sends a request that cannot overlap straight to its end
// check; one that can is squared and put to the exact distance test, and an
// overlap takes a 32-step square root and, unless its distance is zero, two 32-step divisions on one shared divider.
// A closing request that reports overlaps adds two 48-step mean divisions.
// When rsp_if.ready is low the response holds in its output register; the
// sequencer then waits and requests back up into the queue and the front.
// Synchronous reset clears the queue, the sums, the stream position and the
// configuration registers (collision_enable resets to 1).
module circle_overlap_separation_top import cos_pkg::*; #(
   parameter int MAX_CIRCLES = 256
) (
   input logic clock,
   input logic reset,
   cos_req_if.sink req_if,
   cos_rsp_if.source rsp_if,
   input logic csr_write_en,
   input logic [CsrIdxW-1:0] csr_index,
   input logic [CsrDataW-1:0] csr_wdata
);
   cfg_type cfg_ff;
   entry_type push_entry, head;
   logic push, pop, full, not_empty;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{self_x: '0, self_y: '0, self_radius: '0, self_index: '0,
                     collision_enable: 1'b1};
      end else if (csr_write_en) begin
         case (csr_idx_type'(csr_index))
            CSR_SELF_X: cfg_ff.self_x <= csr_wdata;
            CSR_SELF_Y: cfg_ff.self_y <= csr_wdata;
            CSR_SELF_RADIUS: cfg_ff.self_radius <= csr_wdata[RadW-1:0];
            CSR_SELF_INDEX: cfg_ff.self_index <= csr_wdata[SelfIdxW-1:0];
            CSR_COLLISION_ENABLE: cfg_ff.collision_enable <= csr_wdata[0];
            default: cfg_ff <= cfg_ff;
         endcase
      end
   end

   cos_front #(.MAX_CIRCLES(MAX_CIRCLES)) u_front (
      .clock(clock), .reset(reset), .cfg(cfg_ff), .req_if(req_if),
      .fifo_full(full), .push(push), .push_entry(push_entry)
   );

   cos_fifo u_fifo (
      .clock(clock), .reset(reset), .push(push), .push_entry(push_entry),
      .pop(pop), .full(full), .not_empty(not_empty), .head(head)
   );

   cos_back u_back (
      .clock(clock), .reset(reset), .collision_enable(cfg_ff.collision_enable),
      .fifo_not_empty(not_empty), .head(head), .pop(pop), .rsp_if(rsp_if)
   );
endmodule

### rtl/core/cos_checker.sv
`include "circle_overlap_separation_top_assert.svh"
module cos_checker (
   input logic clock,
   input logic reset,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic [8:0] collision_count,
   input logic [31:0] mean_sep_x,
   input logic [31:0] mean_sep_y
);
   `COS_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid, "response dropped")
   `COS_ASSERT_IMP(a_count_not_one, clock, reset, rsp_valid, collision_count != 9'd1, "count one")
   `COS_ASSERT_IMP(a_zero_means, clock, reset, rsp_valid && collision_count == 9'd0, mean_sep_x == 32'd0 && mean_sep_y == 32'd0, "means not zero")
   `COS_ASSERT_RST(a_reset_idle, clock, reset, !rsp_valid, "response after reset")
endmodule

bind circle_overlap_separation_top cos_checker u_cos_checker (
   .clock(clock), .reset(reset), .rsp_valid(rsp_if.valid), .rsp_ready(rsp_if.ready),
   .collision_count(rsp_if.collision_count), .mean_sep_x(rsp_if.mean_sep_x),
   .mean_sep_y(rsp_if.mean_sep_y)
);

### tb/sv/tb_circle_overlap_separation_top.sv
`timescale 1ns / 100ps

module tb_circle_overlap_separation_top;
   import cos_pkg::*;

   typedef struct {
      logic [CntW-1:0] count;
      logic signed [CoordW-1:0] mx;
      logic signed [CoordW-1:0] my;
   } sep_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write_en = 1'b0;
   logic [CsrIdxW-1:0] csr_index = '0;
   logic [CsrDataW-1:0] csr_wdata = '0;

   cos_req_if req_if();
   cos_rsp_if rsp_if();

   circle_overlap_separation_top uut (
      .clock(clock), .reset(reset), .req_if(req_if.sink), .rsp_if(rsp_if.source),
      .csr_write_en(csr_write_en), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   longint q_x, q_y, q_rad;
   int q_idx;
   bit q_en;
   longint acc_x, acc_y;
   int hits, pos;
   sep_result_type expected_q[$];
   int errors = 0;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   longint cycles = 0;

   initial begin
      forever #1 clock = ~clock;
   end

   initial begin
      req_if.valid = 1'b0;
      req_if.other_x = '0;
      req_if.other_y = '0;
      req_if.other_radius = '0;
      req_if.last_circle = 1'b0;
      rsp_if.ready = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 64'd3000000) begin
         $display("FAIL");
         $finish;
      end
   end

   function automatic longint unsigned sqrt_floor(longint unsigned v);
      longint unsigned r = 0;
      longint unsigned b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   function automatic logic [31:0] mean_sat(longint s, int n);
      longint q = s / n;
      if (q > 64'sd2147483647) q = 64'sd2147483647;
      if (q < -64'sd2147483648) q = -64'sd2147483648;
      return q[31:0];
   endfunction

   task automatic reset_sums();
      acc_x = 0;
      acc_y = 0;
      hits = 0;
      pos = 0;
   endtask

   task automatic predict_circle(logic [31:0] ox, logic [31:0] oy, logic [30:0] orad, bit last);
      longint dx, dy, sx, sy;
      longint unsigned adx, ady, rs, dx2, dy2, r2, len, mag;
      sep_result_type r;
      if (q_en && pos != q_idx && hits < 255) begin
         dx = q_x - longint'($signed(ox));
         dy = q_y - longint'($signed(oy));
         adx = dx < 0 ? -dx : dx;
         ady = dy < 0 ? -dy : dy;
         rs = q_rad + orad;
         if (adx < rs && ady < rs) begin
            dx2 = adx * adx;
            dy2 = ady * ady;
            r2 = rs * rs;
            if (dy2 < r2 && dx2 < r2 - dy2) begin
               len = sqrt_floor(dx2 + dy2);
               hits++;
               if (len != 0) begin
                  mag = rs - len;
                  sx = longint'((adx * mag) / len);
                  sy = longint'((ady * mag) / len);
                  acc_x += dx < 0 ? -sx : sx;
                  acc_y += dy < 0 ? -sy : sy;
               end
            end
         end
      end
      pos = (pos + 1) % 256;
      if (last) begin
         if (q_en && hits != 0) begin
            r.count = CntW'(hits + 1);
            r.mx = mean_sat(acc_x, hits);
            r.my = mean_sat(acc_y, hits);
         end else begin
            r.count = '0;
            r.mx = '0;
            r.my = '0;
         end
         expected_q.insert(expected_q.size(), r);
         reset_sums();
      end
   endtask

   task automatic write_reg(csr_idx_type idx, logic [31:0] val);
      @(negedge clock);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_write_en <= 1'b0;
      case (idx)
         CSR_SELF_X: q_x = longint'($signed(val));
         CSR_SELF_Y: q_y = longint'($signed(val));
         CSR_SELF_RADIUS: q_rad = val[30:0];
         CSR_SELF_INDEX: q_idx = val[7:0];
         CSR_COLLISION_ENABLE: q_en = val[0];
         default: ;
      endcase
   endtask

   task automatic set_query(logic [31:0] x, logic [31:0] y, logic [30:0] rad, logic [7:0] idx,
                            bit en);
      write_reg(CSR_SELF_X, x);
      write_reg(CSR_SELF_Y, y);
      write_reg(CSR_SELF_RADIUS, {1'b0, rad});
      write_reg(CSR_SELF_INDEX, {24'd0, idx});
      write_reg(CSR_COLLISION_ENABLE, {31'd0, en});
   endtask

   task automatic send_circle(logic [31:0] ox, logic [31:0] oy, logic [30:0] orad, bit last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(negedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.other_x <= ox;
      req_if.other_y <= oy;
      req_if.other_radius <= orad;
      req_if.last_circle <= last;
      predict_circle(ox, oy, orad, last);
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic drain();
      req_if.valid <= 1'b0;
      while (expected_q.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
   endtask

   always @(negedge clock) begin
      rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   always @(posedge clock) begin
      sep_result_type e;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (expected_q.size() == 0) begin
            $error("unexpected response");
            errors++;
         end else begin
            e = expected_q.pop_front();
            if (rsp_if.collision_count !== e.count) begin
               $error("collision_count expected %0d actual %0d", e.count,
                      rsp_if.collision_count);
               errors++;
            end
            if (rsp_if.mean_sep_x !== e.mx) begin
               $error("mean_sep_x expected %0d actual %0d", e.mx, rsp_if.mean_sep_x);
               errors++;
            end
            if (rsp_if.mean_sep_y !== e.my) begin
               $error("mean_sep_y expected %0d actual %0d", e.my, rsp_if.mean_sep_y);
               errors++;
            end
         end
      end
   end

   function automatic logic [31:0] near_coord(longint c, int spread);
      longint v = c + $signed($urandom_range(2 * spread)) - spread;
      return v[31:0];
   endfunction

   function automatic logic [31:0] rand_field();
      case ($urandom_range(3))
         0: return $urandom;
         1: return 32'h7fffffff;
         2: return 32'h80000000;
         default: return $urandom_range(32'h000fffff);
      endcase
   endfunction

   task automatic test_directed();
      set_query(32'd0, 32'd0, 31'h00010000, 8'd0, 1'b1);
      send_circle(32'd0, 32'd0, 31'h00010000, 1'b0);
      send_circle(32'd0, 32'd0, 31'h00010000, 1'b0);
      send_circle(32'h00008000, 32'hffff8000, 31'h00010000, 1'b0);
      send_circle(32'h00030000, 32'd0, 31'h00010000, 1'b1);
      send_circle(32'h00001000, 32'd0, 31'd0, 1'b1);
      send_circle(32'h7fffffff, 32'h80000000, 31'h7fffffff, 1'b1);
      drain();
      set_query(32'h80000000, 32'h7fffffff, 31'h7fffffff, 8'd255, 1'b1);
      send_circle(32'h7fffffff, 32'h80000000, 31'h7fffffff, 1'b0);
      send_circle(32'h80000000, 32'h7fffffff, 31'h7fffffff, 1'b0);
      send_circle(32'h80001000, 32'h7fff0000, 31'h00000001, 1'b1);
      drain();
      set_query(32'd0, 32'd0, 31'd0, 8'd1, 1'b1);
      send_circle(32'd5, 32'd5, 31'd0, 1'b1);
      send_circle(32'd0, 32'd0, 31'd0, 1'b1);
      drain();
      set_query(32'd0, 32'd0, 31'h00100000, 8'd0, 1'b0);
      send_circle(32'h00001000, 32'h00002000, 31'h00010000, 1'b0);
      send_circle(32'h00001000, 32'h00002000, 31'h00010000, 1'b1);
      drain();
   endtask

   task automatic test_random(int n_items);
      int sent = 0;
      int len;
      logic [31:0] cx, cy;
      while (sent < n_items) begin
         cx = $urandom_range(3) == 0 ? rand_field() : near_coord(0, 32'h00040000);
         cy = $urandom_range(3) == 0 ? rand_field() : near_coord(0, 32'h00040000);
         set_query(cx, cy, $urandom_range(3) == 0 ? 31'($urandom) : 31'($urandom_range(32'h30000)),
                   8'($urandom_range(7)), $urandom_range(9) != 0);
         repeat ($urandom_range(3)) begin
            len = $urandom_range(9) == 0 ? $urandom_range(20, 40) : $urandom_range(1, 8);
            for (int i = 0; i < len; i++) begin
               if ($urandom_range(4) == 0)
                  send_circle(rand_field(), rand_field(), 31'($urandom), i == len - 1);
               else
                  send_circle(near_coord(longint'($signed(cx)), 32'h00030000),
                              near_coord(longint'($signed(cy)), 32'h00030000),
                              31'($urandom_range(32'h30000)), i == len - 1);
               sent++;
            end
         end
         drain();
      end
   endtask

   task automatic test_hit_overflow();
      set_query(32'd0, 32'd0, 31'h00100000, 8'd200, 1'b1);
      for (int i = 0; i < 300; i++)
         send_circle(32'h00010000 + i, 32'hffff0000, 31'h00100000, i == 299);
      drain();
   endtask

   initial begin
      q_x = 0;
      q_y = 0;
      q_rad = 0;
      q_idx = 0;
      q_en = 1'b1;
      reset_sums();
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_directed();
      test_hit_overflow();
      send_idle_pct = 0;
      recv_stall_pct = 0;
      test_random(110);
      send_idle_pct = 50;
      recv_stall_pct = 0;
      test_random(110);
      send_idle_pct = 0;
      recv_stall_pct = 50;
      test_random(110);
      send_idle_pct = 12;
      recv_stall_pct = 12;
      test_random(110);
      drain();
      if (errors == 0 && expected_q.size() == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end
endmodule

### filelist.f
+incdir+rtl/core
rtl/core/cos_pkg.sv
rtl/core/cos_if.sv
rtl/core/cos_front.sv
rtl/core/cos_fifo.sv
rtl/core/cos_div.sv
rtl/core/cos_back.sv
rtl/core/circle_overlap_separation_top.sv
rtl/core/cos_checker.sv
tb/sv/tb_circle_overlap_separation_top.sv
